FILE: hw/rtl/ctok_pkg.sv
// Shared types, token kind codes and character classification for the C tokenizer.
// Used by ctok_step and c_source_tokenizer; no dependencies.
package ctok_pkg;

    localparam int KW_MAX_LEN = 14;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_STR, M_CHR, M_OP, M_SHIFT2, M_DOT2, M_BSL, M_LCOM, M_BCOM
    } mode_t;

    typedef enum logic [1:0] {
        CFG_COMMENTS, CFG_NEWLINES, CFG_KEYWORDS, CFG_TAG
    } cfg_idx_t;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNKNOWN    = 3'd1;
    localparam logic [2:0] ST_OPEN_STR   = 3'd2;
    localparam logic [2:0] ST_OPEN_CHR   = 3'd3;
    localparam logic [2:0] ST_OPEN_COM   = 3'd4;
    localparam logic [2:0] ST_BACKSLASH  = 3'd5;

    localparam logic [6:0] K_INVAL     = 7'd0;
    localparam logic [6:0] K_EOF       = 7'd1;
    localparam logic [6:0] K_EQ        = 7'd2;
    localparam logic [6:0] K_EQEQ      = 7'd3;
    localparam logic [6:0] K_PLUS      = 7'd4;
    localparam logic [6:0] K_INC       = 7'd5;
    localparam logic [6:0] K_PLUSEQ    = 7'd6;
    localparam logic [6:0] K_MINUS     = 7'd7;
    localparam logic [6:0] K_DEC       = 7'd8;
    localparam logic [6:0] K_MINUSEQ   = 7'd9;
    localparam logic [6:0] K_ASTER     = 7'd10;
    localparam logic [6:0] K_SLASH     = 7'd12;
    localparam logic [6:0] K_SLASHEQ   = 7'd13;
    localparam logic [6:0] K_PERCENT   = 7'd14;
    localparam logic [6:0] K_PIPE      = 7'd16;
    localparam logic [6:0] K_PIPEEQ    = 7'd17;
    localparam logic [6:0] K_OROR      = 7'd18;
    localparam logic [6:0] K_AMP       = 7'd19;
    localparam logic [6:0] K_AMPEQ     = 7'd20;
    localparam logic [6:0] K_ANDAND    = 7'd21;
    localparam logic [6:0] K_CARET     = 7'd22;
    localparam logic [6:0] K_LESSER    = 7'd24;
    localparam logic [6:0] K_GREATER   = 7'd28;
    localparam logic [6:0] K_EXC       = 7'd32;
    localparam logic [6:0] K_QUESTION  = 7'd34;
    localparam logic [6:0] K_TILDE     = 7'd35;
    localparam logic [6:0] K_IDENT     = 7'd36;
    localparam logic [6:0] K_NUM       = 7'd37;
    localparam logic [6:0] K_STR       = 7'd38;
    localparam logic [6:0] K_CHAR      = 7'd39;
    localparam logic [6:0] K_DOT       = 7'd99;
    localparam logic [6:0] K_TDOT      = 7'd100;
    localparam logic [6:0] K_ARROW     = 7'd101;
    localparam logic [6:0] K_COLON     = 7'd102;
    localparam logic [6:0] K_COMMA     = 7'd103;
    localparam logic [6:0] K_SEMICOLON = 7'd104;
    localparam logic [6:0] K_HASH      = 7'd105;
    localparam logic [6:0] K_LPAREN    = 7'd106;
    localparam logic [6:0] K_RPAREN    = 7'd107;
    localparam logic [6:0] K_LBRACE    = 7'd108;
    localparam logic [6:0] K_RBRACE    = 7'd109;
    localparam logic [6:0] K_LBRACKET  = 7'd110;
    localparam logic [6:0] K_RBRACKET  = 7'd111;
    localparam logic [6:0] K_COMMENT   = 7'd112;
    localparam logic [6:0] K_NEWLINE   = 7'd114;

    typedef logic [KW_MAX_LEN-1:0][7:0] word_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  pend_kind;
        logic [31:0] tok_start;
        logic [31:0] byte_pos;
        logic [3:0]  word_len;
        logic        esc;
        logic [31:0] line_num;
        logic [31:0] line_start;
        logic        err;
    } tok_state_t;

    typedef struct packed {
        logic [6:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [2:0]  status;
        logic [31:0] eline;
        logic [31:0] ecol;
        logic        last;
    } res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function automatic res_t mk_tok(input logic [6:0] kind, input logic [31:0] s,
                                    input logic [31:0] e);
        res_t r;
        r.kind   = kind;
        r.start  = s;
        r.length = (e >= s) ? e - s : 32'd0;
        r.status = ST_OK;
        r.eline  = 32'd0;
        r.ecol   = 32'd0;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_err(input logic [2:0] code, input logic [31:0] pos,
                                    input logic [31:0] ln, input logic [31:0] ls);
        res_t r;
        r.kind   = K_INVAL;
        r.start  = pos;
        r.length = 32'd0;
        r.status = code;
        r.eline  = ln;
        r.ecol   = (pos >= ls) ? pos - ls : 32'd0;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_" || b == "$";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] b);
        logic [6:0] k;
        case (b)
            "~":     k = K_TILDE;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            ";":     k = K_SEMICOLON;
            "#":     k = K_HASH;
            "?":     k = K_QUESTION;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACKET;
            "]":     k = K_RBRACKET;
            default: k = K_INVAL;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] oper_kind(input logic [7:0] b);
        logic [6:0] k;
        case (b)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_ASTER;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "!":     k = K_EXC;
            "^":     k = K_CARET;
            "=":     k = K_EQ;
            "|":     k = K_PIPE;
            "&":     k = K_AMP;
            "<":     k = K_LESSER;
            ">":     k = K_GREATER;
            ".":     k = K_DOT;
            default: k = K_INVAL;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] kw_kind(input word_t w, input logic [3:0] len);
        logic [8*KW_MAX_LEN-1:0] v;
        logic [6:0] k;
        v = '0;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < int'(len)) v = {v[8*KW_MAX_LEN-9:0], w[i]};
        end
        case (v)
            "alignas":             k = 7'd40;
            "alignof":             k = 7'd41;
            "auto":                k = 7'd42;
            "break":               k = 7'd43;
            "bool":                k = 7'd44;
            "case":                k = 7'd45;
            "char":                k = 7'd46;
            "const":               k = 7'd47;
            "constexpr":           k = 7'd48;
            "continue":            k = 7'd49;
            "default":             k = 7'd50;
            "do":                  k = 7'd51;
            "double":              k = 7'd52;
            "else":                k = 7'd53;
            "enum":                k = 7'd54;
            "extern":              k = 7'd55;
            "false":               k = 7'd56;
            "float":               k = 7'd57;
            "for":                 k = 7'd58;
            "goto":                k = 7'd59;
            "if":                  k = 7'd60;
            "inline":              k = 7'd61;
            "int":                 k = 7'd62;
            "long":                k = 7'd63;
            "nullptr":             k = 7'd64;
            "register":            k = 7'd65;
            "restrict":            k = 7'd66;
            "return":              k = 7'd67;
            "short":               k = 7'd68;
            "signed":              k = 7'd69;
            "sizeof":              k = 7'd70;
            "static":              k = 7'd71;
            {"static", "_assert"}: k = 7'd72;
            "struct":              k = 7'd73;
            "switch":              k = 7'd74;
            {"thread", "_local"}:  k = 7'd75;
            "true":                k = 7'd76;
            "typedef":             k = 7'd77;
            "typeof":              k = 7'd78;
            {"typeof", "_unqual"}: k = 7'd79;
            "union":               k = 7'd80;
            "unsigned":            k = 7'd81;
            "void":                k = 7'd82;
            "volatile":            k = 7'd83;
            "while":               k = 7'd84;
            "_Alignas":            k = 7'd85;
            "_Alignof":            k = 7'd86;
            "_Atomic":             k = 7'd87;
            "_BitInt":             k = 7'd88;
            "_Bool":               k = 7'd89;
            "_Complex":            k = 7'd90;
            "_Decimal128":         k = 7'd91;
            "_Decimal32":          k = 7'd92;
            "_Decimal64":          k = 7'd93;
            "_Generic":            k = 7'd94;
            "_Imaginary":          k = 7'd95;
            "_Noreturn":           k = 7'd96;
            {"_Static", "_assert"}: k = 7'd97;
            {"_Thread", "_local"}: k = 7'd98;
            default:               k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/ctok_step.sv
// Per-byte scanner step: next tokenizer state and up to four result beats.
// Depends on ctok_pkg.
module ctok_step (
    input  ctok_pkg::tok_state_t st_cur,
    input  ctok_pkg::word_t      wb_cur,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    input  logic                 en_comments,
    input  logic                 en_newlines,
    input  logic                 en_keywords,
    output ctok_pkg::tok_state_t st_nxt,
    output ctok_pkg::word_t      wb_nxt,
    output ctok_pkg::res_t [3:0] res,
    output logic [2:0]           res_cnt
);
    import ctok_pkg::*;

    always_comb begin
        tok_state_t  s;
        word_t       w;
        res_t        rr;
        res_t        rr2;
        logic        have;
        logic        have2;
        logic        again;
        logic        stay;
        logic [6:0]  k;
        logic [6:0]  nk;
        logic [6:0]  wk;
        logic [31:0] p;
        logic [31:0] e;
        logic [2:0]  n;
        logic [7:0]  b;

        s     = st_cur;
        w     = wb_cur;
        b     = data_byte;
        p     = st_cur.byte_pos;
        n     = 3'd0;
        res   = '0;
        again = 1'b1;
        rr    = '0;
        rr2   = '0;
        have  = 1'b0;
        have2 = 1'b0;
        stay  = 1'b0;
        k     = K_INVAL;
        nk    = K_INVAL;
        e     = 32'd0;

        wk = (en_keywords && s.word_len >= 4'd2 && s.word_len <= 4'(KW_MAX_LEN))
             ? kw_kind(w, s.word_len) : K_IDENT;

        if (!s.err) begin
            for (int i = 0; i < 3; i++) begin
                if (again && !s.err) begin
                    again = 1'b0;
                    have  = 1'b0;
                    case (s.mode)
                        M_WORD, M_NUM: begin
                            if (is_alpha(b) || is_digit(b)) begin
                                if (s.word_len < 4'(KW_MAX_LEN)) w[s.word_len] = b;
                                if (s.word_len <= 4'(KW_MAX_LEN)) s.word_len = s.word_len + 4'd1;
                            end else begin
                                rr = mk_tok((s.mode == M_WORD) ? wk : K_NUM, s.tok_start, p);
                                have = 1'b1;
                                s.mode = M_IDLE;
                                again = 1'b1;
                            end
                        end
                        M_STR, M_CHR: begin
                            if (s.esc) s.esc = 1'b0;
                            else if (b == "\\") s.esc = 1'b1;
                            else if (b == ((s.mode == M_STR) ? "\"" : "'")) begin
                                rr = mk_tok((s.mode == M_STR) ? K_STR : K_CHAR, s.tok_start,
                                            sat_inc(p));
                                have = 1'b1;
                                s.mode = M_IDLE;
                            end
                        end
                        M_OP: begin
                            k = s.pend_kind;
                            nk = K_INVAL;
                            stay = 1'b0;
                            case (k)
                                K_ASTER, K_PERCENT, K_EXC, K_CARET: begin
                                    if (b == "=") nk = k + 7'd1;
                                end
                                K_PLUS: begin
                                    if (b == "+") nk = K_INC;
                                    else if (b == "=") nk = K_PLUSEQ;
                                end
                                K_EQ: begin
                                    if (b == "=") nk = K_EQEQ;
                                end
                                K_PIPE: begin
                                    if (b == "|") nk = K_OROR;
                                    else if (b == "=") nk = K_PIPEEQ;
                                end
                                K_AMP: begin
                                    if (b == "&") nk = K_ANDAND;
                                    else if (b == "=") nk = K_AMPEQ;
                                end
                                K_MINUS: begin
                                    if (b == "-") nk = K_DEC;
                                    else if (b == "=") nk = K_MINUSEQ;
                                    else if (b == ">") nk = K_ARROW;
                                end
                                K_LESSER, K_GREATER: begin
                                    if (b == "=") nk = k + 7'd1;
                                    else if (b == ((k == K_LESSER) ? "<" : ">")) begin
                                        s.mode = M_SHIFT2;
                                        stay = 1'b1;
                                    end
                                end
                                K_SLASH: begin
                                    if (b == "*") begin
                                        s.mode = M_BCOM;
                                        s.esc = 1'b0;
                                        stay = 1'b1;
                                    end else if (b == "/") begin
                                        s.mode = M_LCOM;
                                        stay = 1'b1;
                                    end else if (b == "=") nk = K_SLASHEQ;
                                end
                                K_DOT: begin
                                    if (b == ".") begin
                                        s.mode = M_DOT2;
                                        stay = 1'b1;
                                    end
                                end
                                default: nk = K_INVAL;
                            endcase
                            if (!stay) begin
                                s.mode = M_IDLE;
                                have = 1'b1;
                                if (nk != K_INVAL) rr = mk_tok(nk, s.tok_start, sat_inc(p));
                                else begin
                                    rr = mk_tok(k, s.tok_start, p);
                                    again = 1'b1;
                                end
                            end
                        end
                        M_SHIFT2: begin
                            s.mode = M_IDLE;
                            have = 1'b1;
                            if (b == "=") rr = mk_tok(s.pend_kind + 7'd3, s.tok_start, sat_inc(p));
                            else begin
                                rr = mk_tok(s.pend_kind + 7'd2, s.tok_start, p);
                                again = 1'b1;
                            end
                        end
                        M_DOT2: begin
                            have = 1'b1;
                            if (b == ".") begin
                                rr = mk_tok(K_TDOT, s.tok_start, sat_inc(p));
                                s.mode = M_IDLE;
                            end else begin
                                rr = mk_tok(K_DOT, s.tok_start, sat_inc(s.tok_start));
                                s.tok_start = sat_inc(s.tok_start);
                                s.mode = M_OP;
                                s.pend_kind = K_DOT;
                                again = 1'b1;
                            end
                        end
                        M_BSL: begin
                            if (b == "\n") s.mode = M_IDLE;
                            else begin
                                rr = mk_err(ST_BACKSLASH, p, s.line_num, s.line_start);
                                have = 1'b1;
                                s.err = 1'b1;
                                s.mode = M_IDLE;
                            end
                        end
                        M_LCOM: begin
                            if (b == "\n") begin
                                rr = mk_tok(K_COMMENT, s.tok_start, p);
                                have = en_comments;
                                s.mode = M_IDLE;
                                again = 1'b1;
                            end
                        end
                        M_BCOM: begin
                            if (s.esc && b == "/") begin
                                rr = mk_tok(K_COMMENT, s.tok_start, sat_inc(p));
                                have = en_comments;
                                s.mode = M_IDLE;
                            end else s.esc = (b == "*");
                        end
                        default: begin
                            s.mode = M_IDLE;
                            if (!(b >= 8'd1 && b <= 8'd32 && b != "\n")) begin
                                s.tok_start = p;
                                if (is_alpha(b) || is_digit(b)) begin
                                    s.mode = is_alpha(b) ? M_WORD : M_NUM;
                                    w[0] = b;
                                    s.word_len = 4'd1;
                                end else if (b == "\"" || b == "'") begin
                                    s.mode = (b == "\"") ? M_STR : M_CHR;
                                    s.esc = 1'b0;
                                end else if (b == "\n") begin
                                    s.line_num = sat_inc(s.line_num);
                                    s.line_start = sat_inc(p);
                                    rr = mk_tok(K_NEWLINE, p, sat_inc(p));
                                    have = en_newlines;
                                end else if (b == "\\") begin
                                    s.mode = M_BSL;
                                end else if (single_kind(b) != K_INVAL) begin
                                    rr = mk_tok(single_kind(b), p, sat_inc(p));
                                    have = 1'b1;
                                end else if (oper_kind(b) != K_INVAL) begin
                                    s.mode = M_OP;
                                    s.pend_kind = oper_kind(b);
                                end else begin
                                    rr = mk_err(ST_UNKNOWN, p, s.line_num, s.line_start);
                                    have = 1'b1;
                                    s.err = 1'b1;
                                end
                            end
                        end
                    endcase
                    if (have && n < 3'd4) begin
                        res[n[1:0]] = rr;
                        n = n + 3'd1;
                    end
                end
            end

            s.byte_pos = sat_inc(p);

            if (end_of_data && !s.err) begin
                e = s.byte_pos;
                have = 1'b0;
                have2 = 1'b0;
                case (s.mode)
                    M_WORD, M_NUM: begin
                        if (s.mode == M_WORD && en_keywords && s.word_len >= 4'd2 &&
                            s.word_len <= 4'(KW_MAX_LEN))
                            k = kw_kind(w, s.word_len);
                        else
                            k = (s.mode == M_WORD) ? K_IDENT : K_NUM;
                        rr = mk_tok(k, s.tok_start, e);
                        have = 1'b1;
                    end
                    M_STR: begin
                        rr = mk_err(ST_OPEN_STR, e, s.line_num, s.line_start);
                        have = 1'b1;
                        s.err = 1'b1;
                    end
                    M_CHR: begin
                        rr = mk_err(ST_OPEN_CHR, e, s.line_num, s.line_start);
                        have = 1'b1;
                        s.err = 1'b1;
                    end
                    M_OP: begin
                        rr = mk_tok(s.pend_kind, s.tok_start, e);
                        have = 1'b1;
                    end
                    M_SHIFT2: begin
                        rr = mk_tok(s.pend_kind + 7'd2, s.tok_start, e);
                        have = 1'b1;
                    end
                    M_DOT2: begin
                        rr = mk_tok(K_DOT, s.tok_start, sat_inc(s.tok_start));
                        rr2 = mk_tok(K_DOT, sat_inc(s.tok_start), e);
                        have = 1'b1;
                        have2 = 1'b1;
                    end
                    M_BSL: begin
                        rr = mk_err(ST_BACKSLASH, e, s.line_num, s.line_start);
                        have = 1'b1;
                        s.err = 1'b1;
                    end
                    M_LCOM: begin
                        rr = mk_tok(K_COMMENT, s.tok_start, e);
                        have = en_comments;
                    end
                    M_BCOM: begin
                        rr = mk_err(ST_OPEN_COM, e, s.line_num, s.line_start);
                        have = 1'b1;
                        s.err = 1'b1;
                    end
                    default: have = 1'b0;
                endcase
                if (have && n < 3'd4) begin
                    res[n[1:0]] = rr;
                    n = n + 3'd1;
                end
                if (have2 && n < 3'd4) begin
                    res[n[1:0]] = rr2;
                    n = n + 3'd1;
                end
                if (!s.err && n < 3'd4) begin
                    rr = mk_tok(K_EOF, e, e);
                    rr.last = 1'b1;
                    res[n[1:0]] = rr;
                    n = n + 3'd1;
                end
            end
        end

        if (end_of_data) s = '0;

        st_nxt  = s;
        wb_nxt  = w;
        res_cnt = n;
    end

endmodule

FILE: hw/rtl/c_source_tokenizer.sv
// Top level of the C source tokenizer: config registers, scan state and result bundle.
// Depends on ctok_pkg and ctok_step.
//
// Usage: source bytes enter on the input channel (in_valid/in_stall with data_byte and
// end_of_data), one beat per byte. Each accepted byte is scanned in the same cycle and
// its zero to four result beats are loaded into a result bundle register; they leave on
// the output channel (out_valid/out_stall) one beat per cycle while out_stall is low, the
// first in the cycle after the byte is accepted. A byte with at most one beat sustains
// one byte per cycle while out_stall is low; more beats hold the input while they drain.
// The beat with last set closes a text (end-of-file or error); the byte after end_of_data
// opens a new text at offset zero. After an error, bytes are dropped until end_of_data.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always ready and
// take effect on the next byte; source_tag follows the tag register directly.
// Reset clears the scan state and the configuration registers, and empties the bundle.
// When the receiver stalls, the current beat holds and the input stalls once the bundle
// cannot be emptied in the same cycle.
module c_source_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  token_kind,
    output logic [31:0] source_tag,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [2:0]  status,
    output logic [31:0] error_line,
    output logic [31:0] error_column,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ctok_pkg::*;

    logic        comments_reg;
    logic        newlines_reg;
    logic        keywords_reg;
    logic [31:0] tag_reg;

    tok_state_t  state_reg;
    tok_state_t  state_next;
    word_t       word_reg;
    word_t       word_next;
    res_t [3:0]  bundle_reg;
    res_t [3:0]  bundle_next;
    logic [2:0]  rem_reg;
    logic [2:0]  cnt_next;
    logic [1:0]  idx_reg;
    logic        in_accept;
    logic        out_accept;
    res_t        cur;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            comments_reg <= 1'b0;
            newlines_reg <= 1'b0;
            keywords_reg <= 1'b0;
            tag_reg      <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_COMMENTS: comments_reg <= cfg_data[0];
                CFG_NEWLINES: newlines_reg <= cfg_data[0];
                CFG_KEYWORDS: keywords_reg <= cfg_data[0];
                CFG_TAG:      tag_reg      <= cfg_data;
                default:      tag_reg      <= tag_reg;
            endcase
        end
    end

    ctok_step u_step (
        .st_cur      (state_reg),
        .wb_cur      (word_reg),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .en_comments (comments_reg),
        .en_newlines (newlines_reg),
        .en_keywords (keywords_reg),
        .st_nxt      (state_next),
        .wb_nxt      (word_next),
        .res         (bundle_next),
        .res_cnt     (cnt_next)
    );

    assign out_valid  = (rem_reg != 3'd0);
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (rem_reg > 3'd1) || ((rem_reg == 3'd1) && out_stall);
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= '0;
            rem_reg   <= 3'd0;
            idx_reg   <= 2'd0;
        end else if (in_accept) begin
            state_reg <= state_next;
            rem_reg   <= cnt_next;
            idx_reg   <= 2'd0;
        end else if (out_accept) begin
            rem_reg   <= rem_reg - 3'd1;
            idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept) begin
            word_reg   <= word_next;
            bundle_reg <= bundle_next;
        end
    end

    assign cur          = bundle_reg[idx_reg];
    assign token_kind   = cur.kind;
    assign source_tag   = tag_reg;
    assign start_offset = cur.start;
    assign token_length = cur.length;
    assign status       = cur.status;
    assign error_line   = cur.eline;
    assign error_column = cur.ecol;
    assign last         = cur.last;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd4)
        else $error("result count out of range");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty bundle");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && rem_reg == 3'd1 && !in_accept |=> !out_valid)
        else $error("bundle not empty after final beat");

    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> rem_reg == 3'd1)
        else $error("last beat is not the final beat of its bundle");

    a_idx_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, idx_reg} + rem_reg) <= 3'd4)
        else $error("bundle read index past its contents");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for c_source_tokenizer: drives random C-like text and compares tokens.
// Depends on ctok_pkg (kind, status, mode and register codes) and the c_source_tokenizer RTL.
module tb;
    import ctok_pkg::*;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [6:0] KW_BASE = 7'd40;
    localparam int WORD_MAX = 14;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 90;

    typedef struct {
        logic [6:0]  kind;
        logic [31:0] tag;
        logic [31:0] start;
        logic [31:0] len;
        logic [2:0]  st;
        logic [31:0] eline;
        logic [31:0] ecol;
        logic        lst;
    } tok_beat_t;

    class token_scoreboard;
        bit          cmt_en, nl_en, kw_en;
        logic [31:0] tag;
        mode_t       mode;
        logic [6:0]  pend;
        logic [31:0] tstart, bpos, lnum, lstart;
        logic [7:0]  wbuf[WORD_MAX];
        int          wlen;
        bit          esc, err_hold;
        int          n_out;
        tok_beat_t   expq[$];
        int          mism, matched, texts;
        string       kws[59];

        function new();
            kws = '{"alignas", "alignof", "auto", "break", "bool", "case", "char", "const",
                "constexpr", "continue", "default", "do", "double", "else", "enum",
                "extern", "false", "float", "for", "goto", "if", "inline", "int", "long",
                "nullptr", "register", "restrict", "return", "short", "signed", "sizeof",
                "static", {"static", "_assert"}, "struct", "switch", {"thread", "_local"},
                "true", "typedef", "typeof", {"typeof", "_unqual"}, "union", "unsigned",
                "void", "volatile", "while", "_Alignas", "_Alignof", "_Atomic", "_BitInt",
                "_Bool", "_Complex", "_Decimal128", "_Decimal32", "_Decimal64",
                "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
                {"_Thread", "_local"}};
            cmt_en = 0; nl_en = 0; kw_en = 0; tag = '0;
            mism = 0; matched = 0; texts = 0;
            clear_text();
        endfunction

        function void clear_text();
            mode = M_IDLE; pend = '0; tstart = '0; bpos = '0; wlen = 0;
            esc = 0; lnum = '0; lstart = '0; err_hold = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_COMMENTS: cmt_en = v[0];
                CFG_NEWLINES: nl_en = v[0];
                CFG_KEYWORDS: kw_en = v[0];
                default:      tag = v;
            endcase
        endfunction

        function logic [31:0] sat_up(logic [31:0] x);
            return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
        endfunction

        function void put(logic [6:0] kind, logic [31:0] s, logic [31:0] len, logic [2:0] st,
                          logic [31:0] el, logic [31:0] ec, logic l);
            tok_beat_t t;
            if (n_out >= 4) return;
            t.kind = kind; t.tag = tag; t.start = s; t.len = len; t.st = st;
            t.eline = el; t.ecol = ec; t.lst = l;
            expq.push_back(t);
            n_out++;
        endfunction

        function void tok(logic [6:0] kind, logic [31:0] s, logic [31:0] e);
            put(kind, s, (e >= s) ? e - s : 32'd0, ST_OK, '0, '0, 1'b0);
        endfunction

        function void fail(logic [2:0] code, logic [31:0] pos);
            put(K_INVAL, pos, '0, code, lnum, (pos >= lstart) ? pos - lstart : 32'd0, 1'b1);
            err_hold = 1;
            mode = M_IDLE;
        endfunction

        function bit alpha(logic [7:0] b);
            return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_" || b == "$";
        endfunction

        function bit wordch(logic [7:0] b);
            return alpha(b) || (b >= "0" && b <= "9");
        endfunction

        function logic [6:0] word_kind();
            string s;
            s = "";
            if (!kw_en || wlen < 2 || wlen > WORD_MAX) return K_IDENT;
            for (int i = 0; i < wlen; i++) s = {s, string'(wbuf[i])};
            for (int i = 0; i < 59; i++)
                if (kws[i] == s) return KW_BASE + 7'(i);
            return K_IDENT;
        endfunction

        function void add_char(logic [7:0] b);
            if (wlen < WORD_MAX) wbuf[wlen] = b;
            if (wlen <= WORD_MAX) wlen++;
        endfunction

        function void close_word(logic [31:0] e);
            tok((mode == M_WORD) ? word_kind() : K_NUM, tstart, e);
            mode = M_IDLE;
        endfunction

        function logic [6:0] one_char_kind(logic [7:0] b);
            case (b)
                "~": return K_TILDE;     ":": return K_COLON;
                ",": return K_COMMA;     ";": return K_SEMICOLON;
                "#": return K_HASH;      "?": return K_QUESTION;
                "(": return K_LPAREN;    ")": return K_RPAREN;
                "{": return K_LBRACE;    "}": return K_RBRACE;
                "[": return K_LBRACKET;  "]": return K_RBRACKET;
                default: return K_INVAL;
            endcase
        endfunction

        function logic [6:0] op_kind(logic [7:0] b);
            case (b)
                "+": return K_PLUS;    "-": return K_MINUS;
                "*": return K_ASTER;   "/": return K_SLASH;
                "%": return K_PERCENT; "!": return K_EXC;
                "^": return K_CARET;   "=": return K_EQ;
                "|": return K_PIPE;    "&": return K_AMP;
                "<": return K_LESSER;  ">": return K_GREATER;
                ".": return K_DOT;
                default: return K_INVAL;
            endcase
        endfunction

        function void start_tok(logic [7:0] b, logic [31:0] p);
            logic [6:0] k;
            if (b >= 8'd1 && b <= 8'd32 && b != CH_NL) return;
            tstart = p;
            if (wordch(b)) begin
                mode = alpha(b) ? M_WORD : M_NUM;
                wlen = 0;
                add_char(b);
            end else if (b == CH_DQ || b == CH_SQ) begin
                mode = (b == CH_DQ) ? M_STR : M_CHR;
                esc = 0;
            end else if (b == CH_NL) begin
                lnum = sat_up(lnum);
                lstart = sat_up(p);
                if (nl_en) tok(K_NEWLINE, p, sat_up(p));
            end else if (b == CH_BSL) begin
                mode = M_BSL;
            end else begin
                k = one_char_kind(b);
                if (k != K_INVAL) tok(k, p, sat_up(p));
                else begin
                    k = op_kind(b);
                    if (k != K_INVAL) begin
                        mode = M_OP;
                        pend = k;
                    end else fail(ST_UNKNOWN, p);
                end
            end
        endfunction

        // returns 1 when the byte must be rescanned from idle
        function bit after_op(logic [7:0] b, logic [31:0] p);
            logic [6:0] k, nk;
            k = pend;
            nk = K_INVAL;
            case (k)
                K_ASTER, K_PERCENT, K_EXC, K_CARET: if (b == "=") nk = k + 7'd1;
                K_PLUS: if (b == "+") nk = K_INC; else if (b == "=") nk = K_PLUSEQ;
                K_EQ: if (b == "=") nk = K_EQEQ;
                K_PIPE: if (b == "|") nk = K_OROR; else if (b == "=") nk = K_PIPEEQ;
                K_AMP: if (b == "&") nk = K_ANDAND; else if (b == "=") nk = K_AMPEQ;
                K_MINUS: begin
                    if (b == "-") nk = K_DEC;
                    else if (b == "=") nk = K_MINUSEQ;
                    else if (b == ">") nk = K_ARROW;
                end
                K_LESSER, K_GREATER: begin
                    if (b == "=") nk = k + 7'd1;
                    else if ((k == K_LESSER && b == "<") || (k == K_GREATER && b == ">")) begin
                        mode = M_SHIFT2;
                        return 0;
                    end
                end
                K_SLASH: begin
                    if (b == "*") begin
                        mode = M_BCOM;
                        esc = 0;
                        return 0;
                    end
                    if (b == "/") begin
                        mode = M_LCOM;
                        return 0;
                    end
                    if (b == "=") nk = K_SLASHEQ;
                end
                K_DOT: begin
                    if (b == ".") begin
                        mode = M_DOT2;
                        return 0;
                    end
                end
                default: ;
            endcase
            mode = M_IDLE;
            if (nk != K_INVAL) begin
                tok(nk, tstart, sat_up(p));
                return 0;
            end
            tok(k, tstart, p);
            return 1;
        endfunction

        function void scan_byte(logic [7:0] b, logic [31:0] p);
            bit again;
            again = 1;
            while (again && !err_hold) begin
                again = 0;
                case (mode)
                    M_WORD, M_NUM: begin
                        if (wordch(b)) add_char(b);
                        else begin
                            close_word(p);
                            again = 1;
                        end
                    end
                    M_STR, M_CHR: begin
                        if (esc) esc = 0;
                        else if (b == CH_BSL) esc = 1;
                        else if (b == ((mode == M_STR) ? CH_DQ : CH_SQ)) begin
                            tok((mode == M_STR) ? K_STR : K_CHAR, tstart, sat_up(p));
                            mode = M_IDLE;
                        end
                    end
                    M_OP: again = after_op(b, p);
                    M_SHIFT2: begin
                        mode = M_IDLE;
                        if (b == "=") tok(pend + 7'd3, tstart, sat_up(p));
                        else begin
                            tok(pend + 7'd2, tstart, p);
                            again = 1;
                        end
                    end
                    M_DOT2: begin
                        if (b == ".") begin
                            tok(K_TDOT, tstart, sat_up(p));
                            mode = M_IDLE;
                        end else begin
                            tok(K_DOT, tstart, sat_up(tstart));
                            tstart = sat_up(tstart);
                            mode = M_OP;
                            pend = K_DOT;
                            again = 1;
                        end
                    end
                    M_BSL: begin
                        if (b == CH_NL) mode = M_IDLE;
                        else fail(ST_BACKSLASH, p);
                    end
                    M_LCOM: begin
                        if (b == CH_NL) begin
                            if (cmt_en) tok(K_COMMENT, tstart, p);
                            mode = M_IDLE;
                            again = 1;
                        end
                    end
                    M_BCOM: begin
                        if (esc && b == "/") begin
                            if (cmt_en) tok(K_COMMENT, tstart, sat_up(p));
                            mode = M_IDLE;
                        end else esc = (b == "*");
                    end
                    default: begin
                        mode = M_IDLE;
                        start_tok(b, p);
                    end
                endcase
            end
        endfunction

        function void close_text(logic [31:0] e);
            case (mode)
                M_WORD, M_NUM: close_word(e);
                M_STR:    fail(ST_OPEN_STR, e);
                M_CHR:    fail(ST_OPEN_CHR, e);
                M_OP:     tok(pend, tstart, e);
                M_SHIFT2: tok(pend + 7'd2, tstart, e);
                M_DOT2: begin
                    tok(K_DOT, tstart, sat_up(tstart));
                    tok(K_DOT, sat_up(tstart), e);
                end
                M_BSL:    fail(ST_BACKSLASH, e);
                M_LCOM:   if (cmt_en) tok(K_COMMENT, tstart, e);
                M_BCOM:   fail(ST_OPEN_COM, e);
                default: ;
            endcase
            if (!err_hold) put(K_EOF, e, '0, ST_OK, '0, '0, 1'b1);
        endfunction

        function void note_byte(logic [7:0] b, logic e);
            n_out = 0;
            if (!err_hold) begin
                scan_byte(b, bpos);
                bpos = sat_up(bpos);
                if (e && !err_hold) close_text(bpos);
            end
            if (e) begin
                clear_text();
                texts++;
            end
        endfunction

        function void check_beat(tok_beat_t got);
            tok_beat_t w;
            if (expq.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("unexpected beat: kind %0d start %0d len %0d status %0d",
                             got.kind, got.start, got.len, got.st);
                return;
            end
            w = expq.pop_front();
            if (got.kind !== w.kind || got.tag !== w.tag || got.start !== w.start ||
                got.len !== w.len || got.st !== w.st || got.eline !== w.eline ||
                got.ecol !== w.ecol || got.lst !== w.lst) begin
                mism++;
                if (mism <= 10) begin
                    $display("mismatch exp: kind %0d tag %h start %0d len %0d st %0d line %0d col %0d last %0d",
                             w.kind, w.tag, w.start, w.len, w.st, w.eline, w.ecol, w.lst);
                    $display("         got: kind %0d tag %h start %0d len %0d st %0d line %0d col %0d last %0d",
                             got.kind, got.tag, got.start, got.len, got.st, got.eline, got.ecol,
                             got.lst);
                end
            end else matched++;
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [7:0]  data_byte;
    logic        end_of_data;
    logic        out_valid, out_stall;
    logic [6:0]  token_kind;
    logic [31:0] source_tag, start_offset, token_length, error_line, error_column;
    logic [2:0]  status;
    logic        last;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    token_scoreboard sb;
    int  src_idle, snk_idle;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;
    int  bytes_sent;

    c_source_tokenizer DUT (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0; data_byte = '0; end_of_data = 0;
        out_stall = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1;
            end
            else
                out_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    always @(posedge clk)
    begin
        tok_beat_t b;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                b.kind = token_kind; b.tag = source_tag; b.start = start_offset;
                b.len = token_length; b.st = status; b.eline = error_line;
                b.ecol = error_column; b.lst = last;
                sb.check_beat(b);
            end
            if (in_valid && !in_stall)
                sb.note_byte(data_byte, end_of_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("** c_source_tokenizer: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
        cfg_valid <= 0;
    endtask

    task automatic send_byte(logic [7:0] b, logic e);
        if ($urandom_range(99) < src_idle)
        begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        in_valid <= 1;
        data_byte <= b;
        end_of_data <= e;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(logic [7:0] t[$]);
        foreach (t[i]) send_byte(t[i], i == t.size() - 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.expq.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void add_str(ref logic [7:0] t[$], input string s);
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    endfunction

    function automatic logic [7:0] body_char();
        case ($urandom_range(9))
            0: return CH_BSL;
            1: return CH_NL;
            2: return "*";
            3: return "/";
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic void make_text(ref logic [7:0] t[$]);
        string ops[48] = '{"=", "==", "+", "++", "+=", "-", "--", "-=", "->", "*", "*=", "/",
            "/=", "%", "%=", "|", "|=", "||", "&", "&=", "&&", "^", "^=", "<", "<=", "<<",
            "<<=", ">", ">=", ">>", ">>=", "!", "!=", "?", "~", ".", "..", "...", ":", ",",
            ";", "#", "(", ")", "{", "}", "[", "]"};
        string wch;
        int n;
        logic [7:0] c;
        wch = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_$0123456789";
        t.delete();
        n = $urandom_range(2, 10);
        for (int f = 0; f < n; f++)
        begin
            case ($urandom_range(14))
                0: add_str(t, sb.kws[$urandom_range(58)]);
                1:
                begin
                    t.push_back(wch[$urandom_range(53)]);
                    repeat ($urandom_range(0, 17)) t.push_back(wch[$urandom_range(63)]);
                end
                2:
                begin
                    t.push_back(wch[$urandom_range(54, 63)]);
                    repeat ($urandom_range(0, 5)) t.push_back(wch[$urandom_range(63)]);
                end
                3, 4:
                begin
                    c = ($urandom_range(1)) ? CH_DQ : CH_SQ;
                    t.push_back(c);
                    repeat ($urandom_range(0, 6)) t.push_back(body_char());
                    if (t[t.size() - 1] == CH_BSL) t.push_back("x");
                    t.push_back(c);
                end
                5, 6: add_str(t, ops[$urandom_range(47)]);
                7:
                begin
                    c = 8'($urandom_range(1, 32));
                    t.push_back((c == CH_NL) ? 8'd32 : c);
                end
                8: t.push_back(CH_NL);
                9:
                begin
                    t.push_back(CH_BSL);
                    t.push_back(CH_NL);
                end
                10:
                begin
                    add_str(t, "//");
                    repeat ($urandom_range(0, 5)) t.push_back(8'($urandom_range(32, 126)));
                    if ($urandom_range(1)) t.push_back(CH_NL);
                end
                11:
                begin
                    add_str(t, "/*");
                    repeat ($urandom_range(0, 6)) t.push_back(body_char());
                    add_str(t, "*/");
                end
                12:
                begin
                    if ($urandom_range(3) == 0) t.push_back(8'($urandom_range(255)));
                    else t.push_back(8'd32);
                end
                default: t.push_back(8'd32);
            endcase
        end
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: t.push_back(CH_DQ);
                1: t.push_back(CH_SQ);
                2: add_str(t, "/*");
                default: t.push_back(CH_BSL);
            endcase
        end
    endfunction

    task automatic random_phase(int count);
        logic [7:0] t[$];
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            make_text(t);
            send_text(t);
        end
    endtask

    initial
    begin
        logic [7:0] t[$];
        sb = new();
        src_idle = 0; snk_idle = 0; hold_req = 0; quiet_cycles = 0; bytes_sent = 0;
        @(posedge rst_n);
        @(posedge clk);
        write_reg(CFG_COMMENTS, 32'd1);
        write_reg(CFG_NEWLINES, 32'd1);
        write_reg(CFG_KEYWORDS, 32'd1);
        write_reg(CFG_TAG, 32'd0);

        // operators, keyword, comment, newline, then unknown-byte, backslash and open-string errors
        t.delete(); add_str(t, "if(a<<=b...c)//q\n"); send_text(t);
        t.delete(); t.push_back(8'h00); send_text(t);
        t.delete(); t.push_back(8'hFF); send_text(t);
        t.delete(); t.push_back(CH_BSL); send_text(t);
        t.delete(); add_str(t, "\"a"); send_text(t);
        drain();

        src_idle = 33; snk_idle = 47;
        random_phase(60);
        drain();
        write_reg(CFG_COMMENTS, 32'd0);
        write_reg(CFG_NEWLINES, 32'd0);
        write_reg(CFG_KEYWORDS, 32'd0);
        write_reg(CFG_TAG, 32'hFFFF_FFFF);

        src_idle = 47; snk_idle = 33;
        random_phase(60);
        drain();
        write_reg(CFG_COMMENTS, 32'd1);
        write_reg(CFG_KEYWORDS, 32'd1);
        write_reg(CFG_TAG, $urandom);

        src_idle = 0; snk_idle = 0;
        hold_req = 1;
        random_phase(60);
        drain();

        $display("covered %0d bytes in %0d texts, %0d tokens checked, %0d mismatches",
                 bytes_sent, sb.texts, sb.matched, sb.mism);
        if (sb.mism == 0 && sb.expq.size() == 0)
            $display("** c_source_tokenizer: PASSED **");
        else
            $display("** c_source_tokenizer: FAILED **");
        $finish;
    end

endmodule
